// ----- sv/sng_pkg.sv -----
package sng_pkg;

  // default sizes
  localparam int HIDDEN_UNITS_DEF = 16;
  localparam int FEATURES_DEF     = 16;
  localparam int MAX_SAMPLES_DEF  = 65535;

  // stream word widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // datapath widths
  localparam int ACC_W   = 48;
  localparam int TERM_W  = 32;
  localparam int VAL_W   = 16;
  localparam int ERR_W   = 17;
  localparam int CNT_W   = 16;
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 54;
  localparam int REQ_W   = 3;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 6;

  localparam logic signed [MUL_B_W-1:0] ONE_Q12 = 17'sd4096;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ACT    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FEAT   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  // read kinds
  localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUT_W  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIDDEN = 2'd2;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_FLAG, OP_SWEEP_INIT, OP_SWEEP, OP_WLOAD,
    OP_SAMPLE, OP_SAMPLE_ACC, OP_ACT_RD, OP_ACT_ACC, OP_ACT_MUL2, OP_ACT_WR,
    OP_FEAT_INIT, OP_FEAT_RD, OP_FEAT_MUL, OP_FEAT_ACC,
    OP_RD_ISSUE, OP_DIV_INIT, OP_DIV_STEP, OP_RD_FIN, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             bad;
    logic             sweep_last;
    logic             feat_last;
    logic             div_last;
    logic             out_free;
  } dp_stat_t;

  // saturating 48-bit add, returns {saturated, sum}
  function automatic logic [ACC_W:0] sat_add48(input logic signed [ACC_W-1:0] a,
                                               input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic [ACC_W:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, 1'b1, {(ACC_W-1){1'b0}}} : {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = {1'b0, s[ACC_W-1:0]};
    end
    return r;
  endfunction

  // saturate to 32 bits signed, returns {saturated, value}
  function automatic logic [TERM_W:0] sat_to32(input logic signed [PROD_W-1:0] v);
    logic [TERM_W:0] r;
    if (v > PROD_W'(64'sd2147483647)) begin
      r = {1'b1, 1'b0, {(TERM_W-1){1'b1}}};
    end else if (v < -PROD_W'(64'sd2147483648)) begin
      r = {1'b1, 1'b1, {(TERM_W-1){1'b0}}};
    end else begin
      r = {1'b0, v[TERM_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ----- sv/shallow_net_gradient_accumulator_core.sv -----
// One word at a time. A load, an unknown type or a rejected item goes straight to its
// result; a sample updates the bias sum; an activation updates a sum and writes its term;
// a feature does one accumulator read-multiply-write per unit; a read runs a 48-step
// divider; a clear sweeps max(FEATURES*HIDDEN_UNITS, HIDDEN_UNITS+1) entries, one entry per cycle.
// rst is synchronous: after it a clearing pass over max(FEATURES*HIDDEN_UNITS,
// HIDDEN_UNITS+1) entries zeroes weights and sums, s_tready low meanwhile.
module shallow_net_gradient_accumulator_core #(
  parameter int HIDDEN_UNITS = sng_pkg::HIDDEN_UNITS_DEF,
  parameter int FEATURES     = sng_pkg::FEATURES_DEF,
  parameter int MAX_SAMPLES  = sng_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // unit_index, feature_index, value, target, zero pad
  input  logic [sng_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type, read_kind
  input  logic [sng_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // gradient
  output logic [sng_pkg::OUT_DATA_W-1:0] m_tdata,
  // error_flag
  output logic [sng_pkg::OUT_USER_W-1:0] m_tuser
);
  import sng_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  sng_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  // arithmetic and stores
  sng_dp #(
    .HIDDEN_UNITS(HIDDEN_UNITS), .FEATURES(FEATURES), .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cmd(cmd), .stat(stat)
  );

endmodule

// ----- sv/sng_ram.sv -----
module sng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sng_ctrl.sv -----
module sng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sng_pkg::dp_stat_t stat,
  output sng_pkg::ctl_cmd_t cmd
);
  import sng_pkg::*;

  typedef enum logic [14:0] {
    S_INIT       = 15'b000000000000001,
    S_IDLE       = 15'b000000000000010,
    S_DECODE     = 15'b000000000000100,
    S_SWEEP      = 15'b000000000001000,
    S_SAMPLE_ACC = 15'b000000000010000,
    S_ACT_ACC    = 15'b000000000100000,
    S_ACT_MUL2   = 15'b000000001000000,
    S_ACT_WR     = 15'b000000010000000,
    S_FEAT_RD    = 15'b000000100000000,
    S_FEAT_MUL   = 15'b000001000000000,
    S_FEAT_ACC   = 15'b000010000000000,
    S_RD_WAIT    = 15'b000100000000000,
    S_DIV        = 15'b001000000000000,
    S_RD_FIN     = 15'b010000000000000,
    S_DONE       = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_INIT: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (stat.req)
          REQ_CLEAR: begin
            cmd.op     = OP_SWEEP_INIT;
            state_next = S_SWEEP;
          end
          REQ_LOAD: cmd.op = OP_WLOAD;
          REQ_SAMPLE: begin
            if (stat.bad) cmd.op = OP_FLAG;
            else begin
              cmd.op     = OP_SAMPLE;
              state_next = S_SAMPLE_ACC;
            end
          end
          REQ_ACT: begin
            if (stat.bad) cmd.op = OP_FLAG;
            else begin
              cmd.op     = OP_ACT_RD;
              state_next = S_ACT_ACC;
            end
          end
          REQ_FEAT: begin
            if (stat.bad) cmd.op = OP_FLAG;
            else begin
              cmd.op     = OP_FEAT_INIT;
              state_next = S_FEAT_RD;
            end
          end
          REQ_READ: begin
            if (stat.bad) cmd.op = OP_FLAG;
            else begin
              cmd.op     = OP_RD_ISSUE;
              state_next = S_RD_WAIT;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_SAMPLE_ACC: begin
        cmd.op     = OP_SAMPLE_ACC;
        state_next = S_DONE;
      end
      S_ACT_ACC: begin
        cmd.op     = OP_ACT_ACC;
        state_next = S_ACT_MUL2;
      end
      S_ACT_MUL2: begin
        cmd.op     = OP_ACT_MUL2;
        state_next = S_ACT_WR;
      end
      S_ACT_WR: begin
        cmd.op     = OP_ACT_WR;
        state_next = S_DONE;
      end
      S_FEAT_RD: begin
        cmd.op     = OP_FEAT_RD;
        state_next = S_FEAT_MUL;
      end
      S_FEAT_MUL: begin
        cmd.op     = OP_FEAT_MUL;
        state_next = S_FEAT_ACC;
      end
      S_FEAT_ACC: begin
        cmd.op     = OP_FEAT_ACC;
        state_next = stat.feat_last ? S_DONE : S_FEAT_RD;
      end
      S_RD_WAIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_next = S_RD_FIN;
      end
      S_RD_FIN: begin
        cmd.op     = OP_RD_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ----- sv/sng_dp.sv -----
module sng_dp #(
  parameter int HIDDEN_UNITS = sng_pkg::HIDDEN_UNITS_DEF,
  parameter int FEATURES     = sng_pkg::FEATURES_DEF,
  parameter int MAX_SAMPLES  = sng_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sng_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [sng_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sng_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [sng_pkg::OUT_USER_W-1:0] m_tuser,
  input  sng_pkg::ctl_cmd_t              cmd,
  output sng_pkg::dp_stat_t              stat
);
  import sng_pkg::*;

  localparam int OW_D      = HIDDEN_UNITS + 1;
  localparam int HW_D      = FEATURES * HIDDEN_UNITS;
  localparam int OW_AW     = $clog2(OW_D);
  localparam int HW_AW     = HW_D > 1 ? $clog2(HW_D) : 1;
  localparam int TU_AW     = HIDDEN_UNITS > 1 ? $clog2(HIDDEN_UNITS) : 1;
  localparam int SWEEP_LEN = HW_D > OW_D ? HW_D : OW_D;
  localparam int SW_AW     = $clog2(SWEEP_LEN);
  localparam int IX_W      = 13;
  localparam int DIVC_W    = 6;

  // latched request
  logic [REQ_W-1:0]         req;
  logic [IDX_W-1:0]         l_idx, n_idx;
  logic [KIND_W-1:0]        kind;
  logic signed [VAL_W-1:0]  val, tgt;

  // sample state
  logic signed [ERR_W-1:0]  err;
  logic [CNT_W-1:0]         cnt;

  // sequencing
  logic [SW_AW-1:0]         sweep;
  logic                     wclr;
  logic [TU_AW-1:0]         j;

  // arithmetic
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [ACC_W-1:0]         dq;
  logic [CNT_W-1:0]         dr;
  logic                     dneg;
  logic [DIVC_W-1:0]        dcnt;
  logic [TERM_W-1:0]        res;
  logic                     flag;

  // memory ports
  logic                     ow_we, ow_re, wt_we, wt_re, tu_we, tu_re, hw_we, hw_re;
  logic [OW_AW-1:0]         ow_waddr, ow_raddr, wt_waddr;
  logic [ACC_W-1:0]         ow_wdata, ow_rdata, hw_wdata, hw_rdata;
  logic [VAL_W-1:0]         wt_wdata, wt_rdata;
  logic [TU_AW-1:0]         tu_waddr, tu_raddr;
  logic [TERM_W-1:0]        tu_wdata, tu_rdata;
  logic [HW_AW-1:0]         hw_waddr, hw_raddr;

  // derived
  logic [IX_W-1:0]          hw_base, hw_rd_ix, hw_ft_ix, sweep_x, l_plus1;
  logic                     load_bad, act_bad, feat_bad, read_bad, full;
  logic [ACC_W:0]           sa_sample, sa_act, sa_feat;
  logic [TERM_W:0]          s32_term, s32_rd;
  logic [CNT_W:0]           dr_sh, dr_sub;
  logic                     dge;
  logic signed [ACC_W:0]    dsigned;
  logic [ACC_W-1:0]         dsel;

  assign hw_base  = IX_W'(n_idx) * IX_W'(HIDDEN_UNITS);
  assign hw_rd_ix = hw_base + IX_W'(l_idx);
  assign hw_ft_ix = hw_base + IX_W'(j);
  assign sweep_x  = IX_W'(sweep);
  assign l_plus1  = IX_W'(l_idx) + IX_W'(1);

  // range checks
  assign load_bad = IX_W'(l_idx) > IX_W'(HIDDEN_UNITS);
  assign act_bad  = IX_W'(l_idx) >= IX_W'(HIDDEN_UNITS);
  assign feat_bad = IX_W'(n_idx) >= IX_W'(FEATURES);
  assign full     = cnt >= CNT_W'(MAX_SAMPLES);
  always_comb begin
    case (kind)
      KIND_BIAS:   read_bad = 1'b0;
      KIND_OUT_W:  read_bad = act_bad;
      KIND_HIDDEN: read_bad = act_bad | feat_bad;
      default:     read_bad = 1'b1;
    endcase
    read_bad = read_bad | (cnt == '0);
  end

  // status to controller
  always_comb begin
    stat.req = req;
    case (req)
      REQ_LOAD:   stat.bad = load_bad;
      REQ_SAMPLE: stat.bad = full;
      REQ_ACT:    stat.bad = act_bad;
      REQ_FEAT:   stat.bad = feat_bad;
      REQ_READ:   stat.bad = read_bad;
      default:    stat.bad = 1'b0;
    endcase
    stat.sweep_last = sweep == SW_AW'(SWEEP_LEN - 1);
    stat.feat_last  = j == TU_AW'(HIDDEN_UNITS - 1);
    stat.div_last   = dcnt == DIVC_W'(ACC_W - 1);
    stat.out_free   = !m_tvalid || m_tready;
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ACT_RD: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(val);
      end
      OP_ACT_ACC: begin
        mul_a = MUL_A_W'($signed(prod[32:0]));
        mul_b = MUL_B_W'($signed(wt_rdata));
      end
      OP_ACT_MUL2: begin
        mul_a = $signed(prod[48:12]);
        mul_b = ONE_Q12 - MUL_B_W'(val);
      end
      OP_FEAT_MUL: begin
        mul_a = MUL_A_W'($signed(tu_rdata));
        mul_b = MUL_B_W'(val);
      end
      default: ;
    endcase
  end

  // saturating updates
  assign sa_sample = sat_add48($signed(ow_rdata), ACC_W'(err) <<< 12);
  assign sa_act    = sat_add48($signed(ow_rdata), ACC_W'($signed(prod[32:0])));
  assign sa_feat   = sat_add48($signed(hw_rdata), ACC_W'($signed(prod[PROD_W-1:12])));
  assign s32_term  = sat_to32(PROD_W'($signed(prod[PROD_W-1:12])));

  // divider step and result sign
  assign dr_sh   = {dr, dq[ACC_W-1]};
  assign dge     = dr_sh >= {1'b0, cnt};
  assign dr_sub  = dr_sh - {1'b0, cnt};
  assign dsigned = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign s32_rd  = sat_to32(PROD_W'(dsigned));
  assign dsel    = (kind == KIND_HIDDEN) ? hw_rdata : ow_rdata;

  // memory port control
  always_comb begin
    ow_we = 1'b0; ow_re = 1'b0; ow_waddr = '0; ow_raddr = '0; ow_wdata = '0;
    wt_we = 1'b0; wt_re = 1'b0; wt_waddr = '0; wt_wdata = '0;
    tu_we = 1'b0; tu_re = 1'b0; tu_waddr = '0; tu_raddr = '0;
    tu_wdata = s32_term[TERM_W-1:0];
    hw_we = 1'b0; hw_re = 1'b0; hw_waddr = '0; hw_raddr = '0; hw_wdata = '0;
    case (cmd.op)
      OP_SWEEP: begin
        ow_we    = sweep_x < IX_W'(OW_D);
        ow_waddr = sweep_x[OW_AW-1:0];
        wt_we    = wclr && (sweep_x < IX_W'(OW_D));
        wt_waddr = sweep_x[OW_AW-1:0];
        hw_we    = sweep_x < IX_W'(HW_D);
        hw_waddr = sweep_x[HW_AW-1:0];
      end
      OP_WLOAD: begin
        wt_we    = !load_bad;
        wt_waddr = l_idx[OW_AW-1:0];
        wt_wdata = val;
      end
      OP_SAMPLE: ow_re = 1'b1;
      OP_SAMPLE_ACC: begin
        ow_we    = 1'b1;
        ow_wdata = sa_sample[ACC_W-1:0];
      end
      OP_ACT_RD: begin
        ow_re    = 1'b1;
        ow_raddr = l_plus1[OW_AW-1:0];
        wt_re    = 1'b1;
      end
      OP_ACT_ACC: begin
        ow_we    = 1'b1;
        ow_waddr = l_plus1[OW_AW-1:0];
        ow_wdata = sa_act[ACC_W-1:0];
      end
      OP_ACT_WR: begin
        tu_we    = 1'b1;
        tu_waddr = l_idx[TU_AW-1:0];
      end
      OP_FEAT_RD: begin
        tu_re    = 1'b1;
        tu_raddr = j;
        hw_re    = 1'b1;
        hw_raddr = hw_ft_ix[HW_AW-1:0];
      end
      OP_FEAT_ACC: begin
        hw_we    = 1'b1;
        hw_waddr = hw_ft_ix[HW_AW-1:0];
        hw_wdata = sa_feat[ACC_W-1:0];
      end
      OP_RD_ISSUE: begin
        ow_re    = 1'b1;
        ow_raddr = (kind == KIND_BIAS) ? '0 : l_plus1[OW_AW-1:0];
        hw_re    = 1'b1;
        hw_raddr = hw_rd_ix[HW_AW-1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      wclr     <= 1'b1;
      err      <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output word valid: set on push, dropped once taken
      if (cmd.op == OP_PUSH) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (cmd.op)
        OP_SWEEP_INIT: begin
          sweep <= '0;
          err   <= '0;
          cnt   <= '0;
        end
        OP_SWEEP: begin
          sweep <= sweep + SW_AW'(1);
          if (stat.sweep_last) wclr <= 1'b0;
        end
        OP_SAMPLE: begin
          err <= ERR_W'(val) - ERR_W'(tgt);
          cnt <= cnt + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        l_idx <= s_tdata[5:0];
        n_idx <= s_tdata[11:6];
        val   <= s_tdata[27:12];
        tgt   <= s_tdata[43:28];
        req   <= s_tuser[2:0];
        kind  <= s_tuser[4:3];
        res   <= '0;
        flag  <= 1'b0;
      end
      OP_FLAG:       flag <= 1'b1;
      OP_WLOAD:      flag <= flag | load_bad;
      OP_SAMPLE_ACC: flag <= flag | sa_sample[ACC_W];
      OP_ACT_RD:     prod <= PROD_W'(mul_a * mul_b);
      OP_ACT_ACC: begin
        prod <= PROD_W'(mul_a * mul_b);
        flag <= flag | sa_act[ACC_W];
      end
      OP_ACT_MUL2:   prod <= PROD_W'(mul_a * mul_b);
      OP_ACT_WR:     flag <= flag | s32_term[TERM_W];
      OP_FEAT_INIT:  j <= '0;
      OP_FEAT_MUL:   prod <= PROD_W'(mul_a * mul_b);
      OP_FEAT_ACC: begin
        flag <= flag | sa_feat[ACC_W];
        j    <= j + TU_AW'(1);
      end
      OP_DIV_INIT: begin
        dneg <= dsel[ACC_W-1];
        dq   <= dsel[ACC_W-1] ? -dsel : dsel;
        dr   <= '0;
        dcnt <= '0;
      end
      OP_DIV_STEP: begin
        dq   <= {dq[ACC_W-2:0], dge};
        dr   <= dge ? dr_sub[CNT_W-1:0] : dr_sh[CNT_W-1:0];
        dcnt <= dcnt + DIVC_W'(1);
      end
      OP_RD_FIN: begin
        res  <= s32_rd[TERM_W-1:0];
        flag <= flag | s32_rd[TERM_W];
      end
      OP_PUSH: begin
        m_tdata <= res;
        m_tuser <= flag;
      end
      default: ;
    endcase
  end

  // stores
  sng_ram #(.WIDTH(VAL_W), .DEPTH(OW_D)) u_wt (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .re(wt_re), .raddr(ow_raddr), .rdata(wt_rdata)
  );
  sng_ram #(.WIDTH(ACC_W), .DEPTH(OW_D)) u_ow (
    .clk(clk), .we(ow_we), .waddr(ow_waddr), .wdata(ow_wdata),
    .re(ow_re), .raddr(ow_raddr), .rdata(ow_rdata)
  );
  sng_ram #(.WIDTH(TERM_W), .DEPTH(HIDDEN_UNITS)) u_tu (
    .clk(clk), .we(tu_we), .waddr(tu_waddr), .wdata(tu_wdata),
    .re(tu_re), .raddr(tu_raddr), .rdata(tu_rdata)
  );
  sng_ram #(.WIDTH(ACC_W), .DEPTH(HW_D)) u_hw (
    .clk(clk), .we(hw_we), .waddr(hw_waddr), .wdata(hw_wdata),
    .re(hw_re), .raddr(hw_raddr), .rdata(hw_rdata)
  );

endmodule
